### sv/page_frame_swap_manager_assert.svh
// Assertion helpers used by the frame swap manager controller.
`ifndef PAGE_FRAME_SWAP_MANAGER_ASSERT_SVH
`define PAGE_FRAME_SWAP_MANAGER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFSM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PFSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/pfsm_pkg.sv
package pfsm_pkg;

    // Fixed field widths of the request and result items and of the configuration port.
    localparam int FUNC_W    = 2;
    localparam int FRAME_W   = 6;
    localparam int STATUS_W  = 3;
    localparam int LIMIT_W   = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [LIMIT_W-1:0] RES_LIMIT_RST  = 7'd16;
    localparam logic [LIMIT_W-1:0] DISK_LIMIT_RST = 7'd32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RES_LIMIT  = 1'b0,
        CFG_DISK_LIMIT = 1'b1
    } t_cfg_idx;

    // Per-frame state held in the frame table.
    typedef enum logic [1:0] {
        FS_UNUSED   = 2'd0,
        FS_RESIDENT = 2'd1,
        FS_SWAPPED  = 2'd2
    } t_fstate;

    // Request operations.
    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC  = 2'd0,
        FN_FREE   = 2'd1,
        FN_ACCESS = 2'd2,
        FN_NOP    = 2'd3
    } t_func;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_FAULT        = 3'd1,
        ST_NO_UNUSED    = 3'd2,
        ST_DISK_FULL    = 3'd3,
        ST_NO_VICTIM    = 3'd4,
        ST_UNUSED_FRAME = 3'd5
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_LOOK,
        S_SCAN,
        S_DECIDE,
        S_WRITE2,
        S_DONE
    } t_state;

    // One result item.
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        t_status            status;
        logic               ev_valid;
        logic [FRAME_W-1:0] ev_frame;
    } t_result;

endpackage

### sv/pfsm_table.sv
module pfsm_table #(
    parameter int FRAMES = 64,
    parameter int AW     = 6
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  pfsm_pkg::t_fstate    i_wr_data,
    input  logic [AW-1:0]        i_rd_addr,
    output pfsm_pkg::t_fstate    o_rd_data
);
    import pfsm_pkg::*;

    t_fstate mem [FRAMES];
    t_fstate r_rd_data;

    // Frame table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/pfsm_ctrl.sv
module pfsm_ctrl #(
    parameter int FRAMES = 64,
    parameter int AW     = 6,
    parameter int CW     = 7
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  pfsm_pkg::t_func                    i_func,
    input  logic [pfsm_pkg::FRAME_W-1:0]       i_idx,
    input  logic [pfsm_pkg::LIMIT_W-1:0]       i_res_limit,
    input  logic [pfsm_pkg::LIMIT_W-1:0]       i_disk_limit,
    input  logic                               i_out_ready,
    output logic                               o_in_ready,
    output logic                               o_res_valid,
    output pfsm_pkg::t_result                  o_result,
    output logic                               o_wr_en,
    output logic [AW-1:0]                      o_wr_addr,
    output pfsm_pkg::t_fstate                  o_wr_data,
    output logic [AW-1:0]                      o_rd_addr,
    input  pfsm_pkg::t_fstate                  i_rd_data
);
    import pfsm_pkg::*;
    `include "page_frame_swap_manager_assert.svh"

    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    t_state              r_state, n_state;
    t_func               r_func, n_func;
    logic [FRAME_W-1:0]  r_idx, n_idx;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_found_free, n_found_free;
    logic [AW-1:0]       r_free_addr, n_free_addr;
    logic                r_found_res, n_found_res;
    logic [AW-1:0]       r_res_addr, n_res_addr;
    logic                r_skip_en, n_skip_en;
    logic [CW-1:0]       r_res_cnt, n_res_cnt;
    logic [CW-1:0]       r_swp_cnt, n_swp_cnt;
    logic [AW-1:0]       r_wr2_addr, n_wr2_addr;
    t_result             r_result, n_result;

    logic                idx_ok;
    logic [AW-1:0]       key;
    logic [AW-1:0]       chk_addr;
    logic                res_full;
    logic                disk_full;
    t_fstate             st_look;
    logic                look_bad;
    logic                look_scan;
    logic                dec_evict;

    // Shared decode of the current request and the table data.
    always_comb begin
        idx_ok    = (32'(r_idx) < 32'(FRAMES));
        key       = AW'(r_idx);
        chk_addr  = AW'(r_cnt - CW'(1));
        res_full  = (LW'(r_res_cnt) >= LW'(i_res_limit));
        disk_full = (LW'(r_swp_cnt) >= LW'(i_disk_limit));
        st_look   = idx_ok ? i_rd_data : FS_UNUSED;
        look_bad  = !((st_look == FS_RESIDENT) || (st_look == FS_SWAPPED));
        look_scan = !look_bad && (r_func == FN_ACCESS) && (st_look == FS_SWAPPED) && res_full;
        if (r_func == FN_ALLOC) begin
            dec_evict = r_found_free && res_full && r_found_res && !disk_full;
        end else begin
            dec_evict = r_found_res && !disk_full;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_cnt == CW'(FRAMES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    case (i_func)
                        FN_ALLOC:  n_state = S_SCAN;
                        FN_FREE:   n_state = S_READ;
                        FN_ACCESS: n_state = S_READ;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_READ:   n_state = S_LOOK;
            S_LOOK:   n_state = look_scan ? S_SCAN : S_DONE;
            S_SCAN: begin
                if (r_cnt == CW'(FRAMES)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: n_state = dec_evict ? S_WRITE2 : S_DONE;
            S_WRITE2: n_state = S_DONE;
            S_DONE: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Table port control and handshake outputs.
    always_comb begin
        o_wr_en     = 1'b0;
        o_wr_addr   = '0;
        o_wr_data   = FS_UNUSED;
        o_rd_addr   = '0;
        o_in_ready  = (r_state == S_IDLE);
        o_res_valid = (r_state == S_DONE);
        o_result    = r_result;
        case (r_state)
            S_CLEAR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_cnt[AW-1:0];
                o_wr_data = FS_UNUSED;
            end
            S_READ: begin
                o_rd_addr = key;
            end
            S_LOOK: begin
                if (!look_bad && !look_scan) begin
                    if (r_func == FN_FREE) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = key;
                        o_wr_data = FS_UNUSED;
                    end else if (st_look == FS_SWAPPED) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = key;
                        o_wr_data = FS_RESIDENT;
                    end
                end
            end
            S_SCAN: begin
                if (32'(r_cnt) < 32'(FRAMES)) begin
                    o_rd_addr = r_cnt[AW-1:0];
                end
            end
            S_DECIDE: begin
                if (dec_evict) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_res_addr;
                    o_wr_data = FS_SWAPPED;
                end else if ((r_func == FN_ALLOC) && r_found_free && !res_full) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_free_addr;
                    o_wr_data = FS_RESIDENT;
                end
            end
            S_WRITE2: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_wr2_addr;
                o_wr_data = FS_RESIDENT;
            end
            default: begin
            end
        endcase
    end

    // Datapath: scan results, counts and the result item.
    always_comb begin
        n_func       = r_func;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_found_free = r_found_free;
        n_free_addr  = r_free_addr;
        n_found_res  = r_found_res;
        n_res_addr   = r_res_addr;
        n_skip_en    = r_skip_en;
        n_res_cnt    = r_res_cnt;
        n_swp_cnt    = r_swp_cnt;
        n_wr2_addr   = r_wr2_addr;
        n_result     = r_result;
        case (r_state)
            S_CLEAR: begin
                n_cnt = r_cnt + CW'(1);
            end
            S_IDLE: begin
                if (i_start) begin
                    n_func       = i_func;
                    n_idx        = i_idx;
                    n_cnt        = '0;
                    n_found_free = 1'b0;
                    n_found_res  = 1'b0;
                    n_skip_en    = 1'b0;
                end
            end
            S_LOOK: begin
                n_result = '{frame: r_idx, status: ST_OK, ev_valid: 1'b0, ev_frame: '0};
                if (look_bad) begin
                    n_result.status = ST_UNUSED_FRAME;
                end else if (r_func == FN_FREE) begin
                    if (st_look == FS_RESIDENT) begin
                        n_res_cnt = r_res_cnt - CW'(1);
                    end else begin
                        n_swp_cnt = r_swp_cnt - CW'(1);
                    end
                end else if (st_look == FS_SWAPPED) begin
                    if (look_scan) begin
                        // Memory full: look for a victim other than this frame.
                        n_skip_en = 1'b1;
                        n_cnt     = '0;
                    end else begin
                        n_res_cnt       = r_res_cnt + CW'(1);
                        n_swp_cnt       = r_swp_cnt - CW'(1);
                        n_result.status = ST_FAULT;
                    end
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt != '0) begin
                    if (!r_found_free && (i_rd_data == FS_UNUSED)) begin
                        n_found_free = 1'b1;
                        n_free_addr  = chk_addr;
                    end
                    if (!r_found_res && (i_rd_data == FS_RESIDENT) &&
                        !(r_skip_en && (chk_addr == key))) begin
                        n_found_res = 1'b1;
                        n_res_addr  = chk_addr;
                    end
                end
            end
            S_DECIDE: begin
                if (r_func == FN_ALLOC) begin
                    n_result = '{frame: '0, status: ST_OK, ev_valid: 1'b0, ev_frame: '0};
                    if (!r_found_free) begin
                        n_result.status = ST_NO_UNUSED;
                    end else if (res_full) begin
                        if (!r_found_res) begin
                            n_result.status = ST_NO_VICTIM;
                        end else if (disk_full) begin
                            n_result.status = ST_DISK_FULL;
                        end else begin
                            n_result.frame    = FRAME_W'(r_free_addr);
                            n_result.ev_valid = 1'b1;
                            n_result.ev_frame = FRAME_W'(r_res_addr);
                            n_swp_cnt         = r_swp_cnt + CW'(1);
                            n_wr2_addr        = r_free_addr;
                        end
                    end else begin
                        n_result.frame = FRAME_W'(r_free_addr);
                        n_res_cnt      = r_res_cnt + CW'(1);
                    end
                end else begin
                    n_result = '{frame: r_idx, status: ST_FAULT, ev_valid: 1'b0, ev_frame: '0};
                    if (!r_found_res) begin
                        n_result.status = ST_NO_VICTIM;
                    end else if (disk_full) begin
                        n_result.status = ST_DISK_FULL;
                    end else begin
                        // Victim and faulting page trade places: counts stay.
                        n_result.ev_valid = 1'b1;
                        n_result.ev_frame = FRAME_W'(r_res_addr);
                        n_wr2_addr        = key;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_res_cnt <= '0;
            r_swp_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_res_cnt <= n_res_cnt;
            r_swp_cnt <= n_swp_cnt;
        end
        r_func       <= n_func;
        r_idx        <= n_idx;
        r_found_free <= n_found_free;
        r_free_addr  <= n_free_addr;
        r_found_res  <= n_found_res;
        r_res_addr   <= n_res_addr;
        r_skip_en    <= n_skip_en;
        r_wr2_addr   <= n_wr2_addr;
        r_result     <= n_result;
    end

    // Checks.
    `PFSM_ASSERT_SAME(a_counts_bounded, i_clk, i_rst_n, 1'b1, ((CW+1)'(r_res_cnt) + (CW+1)'(r_swp_cnt)) <= (CW+1)'(FRAMES), "resident plus swapped count exceeds the table size")
    `PFSM_ASSERT_SAME(a_write2_after_decide, i_clk, i_rst_n, r_state == S_WRITE2, $past(r_state) == S_DECIDE, "second write without an eviction decision")
    `PFSM_ASSERT_SAME(a_no_write_in_scan, i_clk, i_rst_n, r_state == S_SCAN, !o_wr_en, "table written during a scan")
    `PFSM_ASSERT_NEXT(a_start_moves, i_clk, i_rst_n, (r_state == S_IDLE) && i_start && (i_func != FN_NOP), (r_state == S_READ) || (r_state == S_SCAN), "accepted request did not start")

endmodule

### sv/page_frame_swap_manager.sv
// Page frame swap manager.
// Requests enter on the slave stream: tuser carries the operation (allocate, free,
// access) and tdata the frame index. Each allocate, free or access request yields
// exactly one result on the master stream; the reserved operation code is taken
// and dropped without a result. The user writes limits through the configuration
// port only while no request is in flight; the block itself does not enforce this.
// A free or access that needs no table walk (resident, unused, or a fault with
// room) passes through the read, look and done states. An allocate walks the whole
// frame table once through its single read port, then decides, and writes a second
// time when it evicts. A fault while memory is full reads the frame first and then
// walks the table, with a second write when it evicts. One request is worked on at
// a time, so a new request is taken only after the result of the last one has
// been passed to the output register.
// After reset the table is swept to unused, one entry a cycle; no request is taken
// meanwhile, and the limits return to 16 and 32.
// A stalled receiver holds the result in the output register; the block then
// finishes its current request and waits before taking another.
module page_frame_swap_manager #(
    parameter int FRAMES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [pfsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pfsm_pkg::LIMIT_W-1:0]        i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [7:0]                          i_s_tdata,  // [5:0] frame_index
    input  logic [1:0]                          i_s_tuser,  // [1:0] func
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [5:0] result_frame, [8:6] status, [9] evicted_valid, [15:10] evicted_frame
    output logic [15:0]                         o_m_tdata
);
    import pfsm_pkg::*;

    localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);

    logic [LIMIT_W-1:0] r_res_limit;
    logic [LIMIT_W-1:0] r_disk_limit;
    logic               r_out_valid;
    t_result            r_out;

    logic               start;
    logic               in_ready;
    logic               out_ready;
    logic               res_valid;
    t_result            result;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    t_fstate            wr_data;
    logic [AW-1:0]      rd_addr;
    t_fstate            rd_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_limit  <= RES_LIMIT_RST;
            r_disk_limit <= DISK_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RES_LIMIT:  r_res_limit  <= i_cfg_data;
                CFG_DISK_LIMIT: r_disk_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign start      = i_s_tvalid && in_ready;
    assign o_s_tready = in_ready;
    assign out_ready  = !r_out_valid || i_m_tready;

    pfsm_table #(
        .FRAMES (FRAMES),
        .AW     (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    pfsm_ctrl #(
        .FRAMES (FRAMES),
        .AW     (AW),
        .CW     (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_func       (t_func'(i_s_tuser)),
        .i_idx        (i_s_tdata[FRAME_W-1:0]),
        .i_res_limit  (r_res_limit),
        .i_disk_limit (r_disk_limit),
        .i_out_ready  (out_ready),
        .o_in_ready   (in_ready),
        .o_res_valid  (res_valid),
        .o_result     (result),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data)
    );

    // Output register between the controller and the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && out_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && out_ready) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.ev_frame, r_out.ev_valid, r_out.status, r_out.frame};

endmodule
